// File: hdl/course_frame_interpolator_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the course frame interpolator
// Concurrent assertion wrappers, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef COURSE_FRAME_INTERPOLATOR_CORE_DEFINES_SVH
`define COURSE_FRAME_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CFI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFI_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) else $error(msg);
`else
`define CFI_ASSERT(label, clk, rst_n, prop, msg)
`define CFI_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg)
`endif

`endif

// File: hdl/cfi_pkg.sv
// ---------------------------------------------------------------------------
// cfi_pkg
// Shared types and codes of the course frame interpolator.
// ---------------------------------------------------------------------------
package cfi_pkg;

    localparam int IDX_W = 12;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [2:0] ST_SAMPLE = 3'd0;
    localparam logic [2:0] ST_NONE   = 3'd1;
    localparam logic [2:0] ST_STORED = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;

    localparam logic [1:0] OP_RESP   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_KNOT   = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    typedef struct packed {
        logic signed [31:0] prog;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic [15:0]        waypoint;
    } knot_t;

    // word handed from front to back
    typedef struct packed {
        logic [1:0]       op;
        logic [2:0]       status;
        logic [IDX_W-1:0] idx;
        knot_t            knot;
    } cmd_t;

endpackage

// File: hdl/cfi_front.sv
// ---------------------------------------------------------------------------
// cfi_front
// Accepts words, keeps table bookkeeping and classifies each word.
// ---------------------------------------------------------------------------
module cfi_front
    import cfi_pkg::*;
#(
    parameter int KNOT_DEPTH = 256
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         action,
    input  knot_t              knot_in,
    input  logic [30:0]        tol,
    output cmd_t               cmd
);

    localparam int CW = $clog2(KNOT_DEPTH + 1);

    logic [CW-1:0]      total_reg, total_next;
    logic               sound_reg, sound_next;
    logic signed [31:0] first_reg, first_next;
    logic signed [31:0] last_reg, last_next;

    logic signed [33:0] q, tl, pf, pl;
    logic [CW-1:0]      last_idx;

    always_comb
    begin
        q  = 34'(knot_in.prog);
        tl = 34'($signed({1'b0, tol}));
        pf = 34'(first_reg);
        pl = 34'(last_reg);
        last_idx = total_reg - CW'(1);

        total_next = total_reg;
        sound_next = sound_reg;
        first_next = first_reg;
        last_next  = last_reg;

        cmd        = '0;
        cmd.op     = OP_RESP;
        cmd.status = ST_NONE;
        cmd.knot   = knot_in;

        unique case (action)
            ACT_CLEAR:
            begin
                total_next = '0;
                sound_next = 1'b1;
            end
            ACT_APPEND:
            begin
                if (total_reg == CW'(KNOT_DEPTH))
                begin
                    cmd.status = ST_FULL;
                end
                else if (total_reg != '0 && knot_in.prog <= last_reg)
                begin
                    cmd.status = ST_ORDER;
                    sound_next = 1'b0;
                end
                else
                begin
                    cmd.op     = OP_WRITE;
                    cmd.status = ST_STORED;
                    cmd.idx    = IDX_W'(total_reg);
                    total_next = total_reg + CW'(1);
                    last_next  = knot_in.prog;
                    if (total_reg == '0)
                        first_next = knot_in.prog;
                end
            end
            ACT_QUERY:
            begin
                if (!sound_reg || total_reg < CW'(2))
                    cmd.status = ST_NONE;
                else if (q < pf - tl || q > pl + tl)
                    cmd.status = ST_NONE;
                else if (q <= pf + tl)
                begin
                    cmd.op  = OP_KNOT;
                    cmd.idx = '0;
                end
                else if (q >= pl - tl)
                begin
                    cmd.op  = OP_KNOT;
                    cmd.idx = IDX_W'(last_idx);
                end
                else
                begin
                    cmd.op  = OP_SEARCH;
                    cmd.idx = IDX_W'(last_idx);
                end
            end
            default:
            begin
                cmd.status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            sound_reg <= 1'b1;
        end
        else if (accept)
        begin
            total_reg <= total_next;
            sound_reg <= sound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

endmodule

// File: hdl/cfi_queue.sv
// ---------------------------------------------------------------------------
// cfi_queue
// Two-entry queue between front and back.
// ---------------------------------------------------------------------------
module cfi_queue
    import cfi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_word,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_word;
    end

endmodule

// File: hdl/cfi_back.sv
// ---------------------------------------------------------------------------
// cfi_back
// Knot store, binary search, ratio divider and interpolation.
// ---------------------------------------------------------------------------
module cfi_back
    import cfi_pkg::*;
#(
    parameter int KNOT_DEPTH = 256,
    parameter int RATIO_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  cmd_t                  q_head,
    output logic                  q_pop,
    output logic                  done,
    output logic [2:0]            status,
    output logic signed [31:0]    out_progress,
    output logic signed [31:0]    out_x,
    output logic signed [31:0]    out_y,
    output logic signed [15:0]    out_heading,
    output logic [15:0]           from_waypoint,
    output logic [15:0]           to_waypoint,
    output logic [RATIO_BITS-1:0] ratio
);

    localparam int IW = (KNOT_DEPTH > 2) ? $clog2(KNOT_DEPTH) : 1;
    localparam int RB = RATIO_BITS;
    localparam int CNT_W = $clog2(RB + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KNOT = 4'd1;
    localparam logic [3:0] S_SRCH = 4'd2;
    localparam logic [3:0] S_SCMP = 4'd3;
    localparam logic [3:0] S_GLO  = 4'd4;
    localparam logic [3:0] S_GUP  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;

    knot_t mem [KNOT_DEPTH];
    knot_t rd_q;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;

    logic [3:0]    state_reg, state_next;
    logic signed [31:0] qp_reg;
    logic [IW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    knot_t         klo_reg;
    logic [33:0]   rem_reg, rem_next, seg_reg, sh;
    logic [RB-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [33+RB:0] px_reg, py_reg;
    logic signed [16+RB:0] ph_reg;
    logic signed [32:0] dx, dy, seg_w, num_w;
    logic signed [15:0] dh;
    knot_t         kup_reg;

    logic          done_next;
    logic [2:0]    st_next;
    knot_t         ok_next;
    logic [15:0]   to_next;
    logic [RB-1:0] ratio_next;
    logic [IW:0]   mid_sum;

    // knot store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[q_head.idx[IW-1:0]] <= q_head.knot;
        if (rd_en)
            rd_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        done_next  = 1'b0;
        st_next    = ST_NONE;
        ok_next    = '0;
        to_next    = '0;
        ratio_next = '0;
        mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
        sh         = {rem_reg[32:0], 1'b0};
        seg_w      = 33'(rd_q.prog) - 33'(klo_reg.prog);
        num_w      = 33'(qp_reg) - 33'(klo_reg.prog);
        dx         = 33'(kup_reg.x) - 33'(klo_reg.x);
        dy         = 33'(kup_reg.y) - 33'(klo_reg.y);
        dh         = kup_reg.heading - klo_reg.heading;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.op)
                        OP_RESP:
                        begin
                            done_next = 1'b1;
                            st_next   = q_head.status;
                        end
                        OP_WRITE:
                        begin
                            wr_en     = 1'b1;
                            done_next = 1'b1;
                            st_next   = ST_STORED;
                        end
                        OP_KNOT:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = q_head.idx[IW-1:0];
                            state_next = S_KNOT;
                        end
                        default:
                        begin
                            lo_next    = IW'(1);
                            hi_next    = q_head.idx[IW-1:0];
                            state_next = S_SRCH;
                        end
                    endcase
                end
            end
            S_KNOT:
            begin
                done_next  = 1'b1;
                st_next    = ST_SAMPLE;
                ok_next    = rd_q;
                to_next    = rd_q.waypoint;
                state_next = S_IDLE;
            end
            S_SRCH:
            begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[IW:1];
                    rd_addr    = mid_sum[IW:1];
                    state_next = S_SCMP;
                end
                else
                begin
                    rd_addr    = lo_reg - IW'(1);
                    state_next = S_GLO;
                end
            end
            S_SCMP:
            begin
                if (rd_q.prog <= qp_reg)
                    lo_next = mid_reg + IW'(1);
                else
                    hi_next = mid_reg;
                state_next = S_SRCH;
            end
            S_GLO:
            begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg;
                state_next = S_GUP;
            end
            S_GUP:
            begin
                rem_next   = 34'(num_w);
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (sh >= seg_reg)
                begin
                    rem_next = sh - seg_reg;
                    quo_next = {quo_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sh;
                    quo_next = {quo_reg[RB-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RB - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                done_next        = 1'b1;
                st_next          = ST_SAMPLE;
                ok_next.prog     = qp_reg;
                ok_next.x        = klo_reg.x + 32'(px_reg >>> RB);
                ok_next.y        = klo_reg.y + 32'(py_reg >>> RB);
                ok_next.heading  = klo_reg.heading + 16'(ph_reg >>> RB);
                ok_next.waypoint = klo_reg.waypoint;
                to_next          = kup_reg.waypoint;
                ratio_next       = quo_reg;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (state_reg == S_IDLE && q_valid)
            qp_reg <= q_head.knot.prog;
        if (state_reg == S_GLO)
            klo_reg <= rd_q;
        if (state_reg == S_GUP)
        begin
            kup_reg <= rd_q;
            seg_reg <= 34'(seg_w);
        end
        if (state_reg == S_MUL)
        begin
            px_reg <= dx * $signed({1'b0, quo_reg});
            py_reg <= dy * $signed({1'b0, quo_reg});
            ph_reg <= dh * $signed({1'b0, quo_reg});
        end
        status        <= st_next;
        out_progress  <= ok_next.prog;
        out_x         <= ok_next.x;
        out_y         <= ok_next.y;
        out_heading   <= ok_next.heading;
        from_waypoint <= ok_next.waypoint;
        to_waypoint   <= to_next;
        ratio         <= ratio_next;
    end

endmodule

// File: hdl/course_frame_interpolator_core.sv
// ---------------------------------------------------------------------------
// course_frame_interpolator_core
// Path knot table with end-tolerant linear sampling of position and heading.
// ---------------------------------------------------------------------------
// One word at a time: busy rises when a word is taken and falls in the cycle
// after its result is strobed on done, which cannot be held off. An interior
// sample runs a binary search over the single read port of the knot store,
// then the bit-serial ratio divider. Heading is interpolated on the shorter
// arc; a half-turn delta runs the negative way. Knot entries need no
// clearing: only entries below the stored count are ever read.
// ---------------------------------------------------------------------------
`include "course_frame_interpolator_core_defines.svh"

module course_frame_interpolator_core
    import cfi_pkg::*;
#(
    parameter int KNOT_DEPTH = 256,
    parameter int RATIO_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cfg_we,
    input  logic [30:0]           cfg_wdata,
    input  logic [1:0]            action,
    input  logic signed [31:0]    progress,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [15:0]    heading,
    input  logic [15:0]           waypoint,
    output logic                  done,
    output logic [2:0]            status,
    output logic signed [31:0]    out_progress,
    output logic signed [31:0]    out_x,
    output logic signed [31:0]    out_y,
    output logic signed [15:0]    out_heading,
    output logic [15:0]           from_waypoint,
    output logic [15:0]           to_waypoint,
    output logic [RATIO_BITS-1:0] ratio
);

    logic [30:0] tol_reg;
    logic        busy_reg;
    logic        accept;
    knot_t       knot_in;
    cmd_t        front_cmd, head;
    logic        q_valid, q_pop;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    assign knot_in.prog     = progress;
    assign knot_in.x        = pos_x;
    assign knot_in.y        = pos_y;
    assign knot_in.heading  = heading;
    assign knot_in.waypoint = waypoint;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (accept)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;
        end
    end

    // classify against the table bookkeeping
    cfi_front #(.KNOT_DEPTH(KNOT_DEPTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (action),
        .knot_in (knot_in),
        .tol     (tol_reg),
        .cmd     (front_cmd)
    );

    cfi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (front_cmd),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head)
    );

    // store, search, divide, interpolate
    cfi_back #(.KNOT_DEPTH(KNOT_DEPTH), .RATIO_BITS(RATIO_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (head),
        .q_pop         (q_pop),
        .done          (done),
        .status        (status),
        .out_progress  (out_progress),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_heading   (out_heading),
        .from_waypoint (from_waypoint),
        .to_waypoint   (to_waypoint),
        .ratio         (ratio)
    );

    `CFI_ASSERT(a_done_busy, clk, rst_n, done |-> busy_reg, "result without word in flight")
    `CFI_ASSERT_NEXT(a_acc_busy, clk, rst_n, accept, busy_reg, "busy not raised on accept")
    `CFI_ASSERT_NEXT(a_one_done, clk, rst_n, done, !done && !busy_reg, "repeated result")
    `CFI_ASSERT(a_q_busy, clk, rst_n, q_valid |-> busy_reg, "queued word while idle")

endmodule
